FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vt52_pkg.sv
`default_nettype none
package vt52_pkg;
  localparam int unsigned MaxColsDef = 128;
  localparam int unsigned MaxRowsDef = 64;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharEsc = 8'd27;
  localparam logic [7:0] CharBs = 8'd8;
  localparam logic [7:0] CharTab = 8'd9;
  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharDel = 8'd127;
  localparam logic [0:0] RegColumns = 1'b0;
  localparam logic [0:0] RegRows = 1'b1;

  // escape phases
  localparam logic [2:0] PhText = 3'd0;
  localparam logic [2:0] PhEsc = 3'd1;
  localparam logic [2:0] PhRow = 3'd2;
  localparam logic [2:0] PhCol = 3'd3;
  localparam logic [2:0] PhColorFg = 3'd4;  // byte after esc b is dropped
  localparam logic [2:0] PhColorBg = 3'd5;  // byte after esc c is dropped
  localparam logic [2:0] PhCsi = 3'd6;
endpackage
`default_nettype wire

FILE: src/vt52_screen_mem.sv
`default_nettype none
`include "assert_macros.svh"
module vt52_screen_mem #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];
  logic       re_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= 1'b0;
    end else begin
      re_q <= re_i;
    end
  end

  `ASSERT_ALWAYS(a_no_same_cycle_rw, !(we_i && re_i && waddr_i == raddr_i), "rw same entry")
  `ASSERT_NEXT(a_read_tracked, re_i, re_q, "read flag lost")
  `ASSERT_ALWAYS(a_addr_in_range, !we_i || (32'(waddr_i) < Depth), "write out of range")
endmodule
`default_nettype wire

FILE: src/vt52_text_terminal_engine_unit.sv
`default_nettype none
`include "assert_macros.svh"
// vt52 text terminal engine
// input channel: in_valid_i / in_stall_o with kind_i, data_byte_i, read_row_i, read_col_i.
//   kind 0 interprets a host byte, kind 1 reads one screen cell.
// output channel: out_valid_o / out_stall_i, one result per request with the cell read,
//   cursor position, colors and mode flags after the request.
// configuration: cfg_valid_i / cfg_ready_o, cfg_index_i (0 columns, 1 rows), cfg_data_i.
//   a write blanks the screen (a sweep over all MaxRows*MaxCols cells) and clamps the cursor.
// sequencing: a cell read loads its result in StRead, a control or escape byte in StOut,
//   and the next request waits for the engine to return to StIdle;
//   a printable byte first writes its cell in StGlyph, then goes to StOut.
//   tab writes up to 8 cells, one per cycle unless a scroll sweep comes between; erase
//   and scroll commands sweep cells one per cycle, with an extra step at each row change.
// reset: a clearing pass over all MaxRows*MaxCols cells writes spaces to every cell;
//   in_stall_o stays high until it ends. configuration writes are taken only while
//   idle or clearing, and in_stall_o is high while cfg_valid_i is.
// a stalled result holds its value; a new request waits for the engine to go idle
//   and for the result register to be free.
module vt52_text_terminal_engine_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [5:0] read_row_i,
  input  wire logic [6:0] read_col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] cell_char_o,
  output logic      [6:0] cursor_col_o,
  output logic      [5:0] cursor_row_o,
  output logic      [3:0] fg_color_o,
  output logic      [3:0] bg_color_o,
  output logic            bold_on_o,
  output logic            cursor_enabled_o,
  output logic            reverse_video_o,
  output logic            wrap_enabled_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  // screen ring size, powers of two matching the port widths
  localparam int unsigned MaxCols = vt52_pkg::MaxColsDef;
  localparam int unsigned MaxRows = vt52_pkg::MaxRowsDef;
  localparam int unsigned CW = $clog2(MaxCols);
  localparam int unsigned RW = $clog2(MaxRows);
  localparam int unsigned AW = CW + RW;
  localparam int unsigned Depth = MaxCols * MaxRows;

  typedef enum logic [6:0] {
    StClear  = 7'b0000001,
    StIdle   = 7'b0000010,
    StRead   = 7'b0000100,
    StGlyph  = 7'b0001000,
    StSweep  = 7'b0010000,
    StOut    = 7'b0100000,
    StBsPost = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration, effective sizes kept as values 1..Max
  logic [8:0] ncols_q, ncols_d;
  logic [7:0] nrows_q, nrows_d;
  logic [RW-1:0] top_q, top_d;
  logic [6:0] ccol_q, ccol_d, scol_q, scol_d;
  logic [5:0] crow_q, crow_d, srow_q, srow_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] arg0_q, arg0_d, arg1_q, arg1_d;
  logic       argi_q, argi_d;
  logic [3:0] fg_q, fg_d, bg_q, bg_d;
  logic       bold_q, bold_d, wrap_q, wrap_d, curs_q, curs_d, rev_q, rev_d;
  logic [7:0] byte_q, byte_d;
  logic       inarea_q, inarea_d;
  logic [3:0] tabn_q, tabn_d;
  logic       istab_q, istab_d;
  logic       isbs_q, isbs_d;

  // sweep state
  logic [AW:0]  swcnt_q, swcnt_d;   // used during clear
  logic [7:0]   swrow_q, swrow_d, swlast_q, swlast_d;
  logic [8:0]   swcol_q, swcol_d, swend_q, swend_d;

  // memory port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // result register
  logic       ovalid_q;
  logic [7:0] ochar_q, ochar_d;
  logic       oload;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] top, input logic [7:0] r,
                                            input logic [8:0] c);
    logic [RW-1:0] phys;
    phys = top + r[RW-1:0];
    return {phys, c[CW-1:0]};
  endfunction

  function automatic logic [8:0] clamp_cols(input logic [7:0] v);
    if (v == 8'd0) return 9'd1;
    if ({1'b0, v} > 9'(MaxCols)) return 9'(MaxCols);
    return {1'b0, v};
  endfunction

  function automatic logic [7:0] clamp_rows(input logic [6:0] v);
    if (v == 7'd0) return 8'd1;
    if ({1'b0, v} > 8'(MaxRows)) return 8'(MaxRows);
    return {1'b0, v};
  endfunction

  vt52_screen_mem #(.Depth(Depth), .AddrW(AW)) u_mem (
    .clk_i, .rst_ni,
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  // writes only between requests, never together with an input accept
  assign cfg_ready_o = (state_q == StIdle) || (state_q == StClear);
  assign in_stall_o = !(state_q == StIdle) || (ovalid_q && out_stall_i) || cfg_valid_i;

  wire in_acc  = in_valid_i && !in_stall_o;
  wire cfg_acc = cfg_valid_i && cfg_ready_o;

  always_comb begin
    logic [8:0] nc;
    logic [7:0] nr;
    logic [8:0] col1;
    logic [7:0] v;
    logic [11:0] acc;
    logic        adv;
    logic [7:0]  b;
    state_d = state_q;
    ncols_d = ncols_q; nrows_d = nrows_q; top_d = top_q;
    ccol_d = ccol_q; crow_d = crow_q; scol_d = scol_q; srow_d = srow_q;
    phase_d = phase_q; arg0_d = arg0_q; arg1_d = arg1_q; argi_d = argi_q;
    fg_d = fg_q; bg_d = bg_q; bold_d = bold_q; wrap_d = wrap_q;
    curs_d = curs_q; rev_d = rev_q;
    byte_d = byte_q; inarea_d = inarea_q;
    tabn_d = tabn_q; istab_d = istab_q; isbs_d = isbs_q;
    swcnt_d = swcnt_q; swrow_d = swrow_q; swlast_d = swlast_q;
    swcol_d = swcol_q; swend_d = swend_q;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = vt52_pkg::CharSpace;
    ochar_d = 8'd0; oload = 1'b0;
    nc = ncols_q; nr = nrows_q;
    col1 = 9'd0; v = 8'd0; acc = 12'd0; adv = 1'b0; b = byte_q;

    unique case (state_q)
      StClear: begin
        we = 1'b1;
        waddr = swcnt_q[AW-1:0];
        swcnt_d = swcnt_q + 1'b1;
        if (swcnt_q == (AW+1)'(Depth - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc) begin
          byte_d = data_byte_i;
          istab_d = 1'b0; isbs_d = 1'b0;
          if (kind_i) begin
            inarea_d = ({2'b0, read_row_i} < nr) && ({2'b0, read_col_i} < nc);
            re = 1'b1;
            raddr = addr_of(top_q, {2'b0, read_row_i}, {2'b0, read_col_i});
            state_d = StRead;
          end else begin
            b = data_byte_i;
            state_d = StOut;
            priority case (phase_q)
              vt52_pkg::PhText: begin
                if (b == vt52_pkg::CharBs) begin
                  if (ccol_q != 7'd0) ccol_d = ccol_q - 7'd1;
                  isbs_d = 1'b1; byte_d = vt52_pkg::CharSpace; state_d = StGlyph;
                end else if (b == vt52_pkg::CharTab) begin
                  istab_d = 1'b1; tabn_d = 4'd0; byte_d = vt52_pkg::CharSpace;
                  state_d = StGlyph;
                end else if (b == vt52_pkg::CharLf) begin
                  if ({2'b0, crow_q} + 8'd1 >= nr) begin
                    top_d = top_q + 1'b1;
                    swrow_d = nr - 8'd1; swlast_d = nr - 8'd1;
                    swcol_d = 9'd0; swend_d = 9'(MaxCols);
                    state_d = StSweep;
                  end else crow_d = crow_q + 6'd1;
                end else if (b == vt52_pkg::CharCr) begin
                  ccol_d = 7'd0;
                end else if (b == vt52_pkg::CharEsc) begin
                  phase_d = vt52_pkg::PhEsc;
                end else if (b >= 8'd32 && b != vt52_pkg::CharDel) begin
                  state_d = StGlyph;
                end
              end
              vt52_pkg::PhEsc: begin
                phase_d = vt52_pkg::PhText;
                swcol_d = 9'd0; swend_d = nc;
                swrow_d = {2'b0, crow_q}; swlast_d = {2'b0, crow_q};
                unique case (b)
                  "A", "I": if (crow_q != 6'd0) crow_d = crow_q - 6'd1;
                  "B": if ({2'b0, crow_q} + 8'd1 < nr) crow_d = crow_q + 6'd1;
                  "C": if ({2'b0, ccol_q} + 9'd1 < nc) ccol_d = ccol_q + 7'd1;
                  "D": if (ccol_q != 7'd0) ccol_d = ccol_q - 7'd1;
                  "E": begin
                    swrow_d = 8'd0; swlast_d = nr - 8'd1;
                    ccol_d = 7'd0; crow_d = 6'd0; state_d = StSweep;
                  end
                  "H": begin ccol_d = 7'd0; crow_d = 6'd0; end
                  "J": begin
                    swcol_d = {2'b0, ccol_q}; swlast_d = nr - 8'd1; state_d = StSweep;
                  end
                  "K": begin swcol_d = {2'b0, ccol_q}; state_d = StSweep; end
                  "L", "M": begin
                    if ({2'b0, crow_q} + 8'd1 < nr) begin
                      top_d = top_q + 1'b1;
                      swrow_d = nr - 8'd1; swlast_d = nr - 8'd1;
                      swend_d = 9'(MaxCols); state_d = StSweep;
                    end
                    ccol_d = 7'd0;
                  end
                  "Y": phase_d = vt52_pkg::PhRow;
                  "b": phase_d = vt52_pkg::PhColorFg;
                  "c": phase_d = vt52_pkg::PhColorBg;
                  "d": begin
                    swrow_d = 8'd0; swend_d = {2'b0, ccol_q}; state_d = StSweep;
                  end
                  "e": curs_d = 1'b1;
                  "f": curs_d = 1'b0;
                  "j": begin scol_d = ccol_q; srow_d = crow_q; end
                  "k": begin ccol_d = scol_q; crow_d = srow_q; end
                  "l": begin ccol_d = 7'd0; state_d = StSweep; end
                  "o": begin swend_d = {2'b0, ccol_q}; state_d = StSweep; end
                  "p": rev_d = 1'b1;
                  "q": rev_d = 1'b0;
                  "v": wrap_d = 1'b1;
                  "w": wrap_d = 1'b0;
                  "[": phase_d = vt52_pkg::PhCsi;
                  default: ;
                endcase
              end
              vt52_pkg::PhRow: begin
                v = b - 8'd32;
                crow_d = (v >= nr) ? 6'(nr - 8'd1) : v[5:0];
                phase_d = vt52_pkg::PhCol;
              end
              vt52_pkg::PhCol: begin
                v = b - 8'd32;
                ccol_d = ({1'b0, v} >= nc) ? 7'(nc - 9'd1) : v[6:0];
                phase_d = vt52_pkg::PhText;
              end
              vt52_pkg::PhCsi: begin
                if (b == "m") begin
                  for (int i = 0; i < 2; i++) begin
                    if (i == 0 || argi_q) begin
                      v = (i == 0) ? arg0_q : arg1_q;
                      if (v == 8'd0) begin
                        fg_d = 4'd0; bg_d = 4'd15; bold_d = 1'b0;
                      end else if (v == 8'd1) begin
                        if (fg_d < 4'd8) fg_d = fg_d + 4'd8;
                        bold_d = 1'b1;
                      end else if (v == 8'd39) fg_d = 4'd0;
                      else if (v == 8'd49) bg_d = 4'd15;
                      else if (v >= 8'd30 && v <= 8'd37) begin
                        fg_d = 4'(v - 8'd30);
                        if (bold_d) fg_d = fg_d + 4'd8;
                      end else if (v >= 8'd40 && v <= 8'd47) bg_d = 4'(v - 8'd40);
                    end
                  end
                  arg0_d = 8'd0; arg1_d = 8'd0; argi_d = 1'b0;
                  phase_d = vt52_pkg::PhText;
                end else if (b == ";") argi_d = 1'b1;
                else if (b >= "0" && b <= "9") begin
                  acc = 12'(argi_q ? arg1_q : arg0_q) * 12'd10 + 12'(b - "0");
                  v = (acc > 12'd255) ? 8'hff : acc[7:0];
                  if (argi_q) arg1_d = v; else arg0_d = v;
                end
              end
              default: phase_d = vt52_pkg::PhText;
            endcase
          end
        end
      end
      StRead: begin
        ochar_d = inarea_q ? rdata : 8'd0;
        oload = 1'b1;
        state_d = StIdle;
      end
      StGlyph: begin
        // one cell write and cursor advance per cycle
        we = 1'b1;
        waddr = addr_of(top_q, {2'b0, crow_q}, {2'b0, ccol_q});
        wdata = byte_q;
        col1 = {2'b0, ccol_q} + 9'd1;
        adv = 1'b0;
        state_d = StOut;
        if (col1 >= nc) begin
          if (!wrap_q) begin
            ccol_d = 7'(nc - 9'd1);
            adv = 1'b1;  // clamped: ends tab
          end else begin
            ccol_d = 7'd0;
            if ({2'b0, crow_q} + 8'd1 >= nr) begin
              top_d = top_q + 1'b1;
              crow_d = 6'(nr - 8'd1);
              swrow_d = nr - 8'd1; swlast_d = nr - 8'd1;
              swcol_d = 9'd0; swend_d = 9'(MaxCols);
              state_d = StSweep;
            end else crow_d = crow_q + 6'd1;
          end
        end else ccol_d = col1[6:0];
        if (istab_q && !adv && ccol_d[2:0] != 3'd0 && tabn_q != 4'd7) begin
          tabn_d = tabn_q + 4'd1;
          if (state_d == StOut) state_d = StGlyph;
        end else begin
          istab_d = 1'b0;
        end
        if (isbs_q && state_d == StOut) state_d = StBsPost;
      end
      StBsPost: begin
        if (ccol_q != 7'd0) ccol_d = ccol_q - 7'd1;
        isbs_d = 1'b0;
        state_d = StOut;
      end
      StSweep: begin
        if (swrow_q > swlast_q || (swrow_q == swlast_q && swcol_q >= swend_q)
            || (swrow_q != swlast_q && swcol_q >= nc && swend_q != 9'(MaxCols))) begin
          if (swrow_q >= swlast_q) begin
            // finished; a tab still in progress resumes, a backspace goes on to StBsPost
            state_d = istab_q ? StGlyph : (isbs_q ? StBsPost : StOut);
          end else begin
            swrow_d = swrow_q + 8'd1; swcol_d = 9'd0;
          end
        end else if (swcol_q >= 9'(MaxCols)) begin
          swrow_d = swrow_q + 8'd1; swcol_d = 9'd0;
        end else begin
          we = 1'b1;
          waddr = addr_of(top_q, swrow_q, swcol_q);
          swcol_d = swcol_q + 9'd1;
        end
      end
      StOut: begin
        ochar_d = 8'd0;
        oload = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase

    if (cfg_acc) begin
      if (cfg_index_i == vt52_pkg::RegColumns) nc = clamp_cols(cfg_data_i);
      else nr = clamp_rows(cfg_data_i[6:0]);
      ncols_d = nc; nrows_d = nr; top_d = '0;
      if ({2'b0, ccol_q} >= nc) ccol_d = 7'(nc - 9'd1);
      if ({2'b0, crow_q} >= nr) crow_d = 6'(nr - 8'd1);
      if ({2'b0, scol_q} >= nc) scol_d = 7'(nc - 9'd1);
      if ({2'b0, srow_q} >= nr) srow_d = 6'(nr - 8'd1);
      swcnt_d = '0;
      state_d = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ncols_q <= 9'd80; nrows_q <= 8'd25; top_q <= '0;
      ccol_q <= '0; crow_q <= '0; scol_q <= '0; srow_q <= '0;
      phase_q <= vt52_pkg::PhText; arg0_q <= '0; arg1_q <= '0; argi_q <= 1'b0;
      fg_q <= 4'd0; bg_q <= 4'd15; bold_q <= 1'b0; wrap_q <= 1'b1;
      curs_q <= 1'b1; rev_q <= 1'b0;
      istab_q <= 1'b0; isbs_q <= 1'b0; tabn_q <= '0;
      swcnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ncols_q <= ncols_d; nrows_q <= nrows_d; top_q <= top_d;
      ccol_q <= ccol_d; crow_q <= crow_d; scol_q <= scol_d; srow_q <= srow_d;
      phase_q <= phase_d; arg0_q <= arg0_d; arg1_q <= arg1_d; argi_q <= argi_d;
      fg_q <= fg_d; bg_q <= bg_d; bold_q <= bold_d; wrap_q <= wrap_d;
      curs_q <= curs_d; rev_q <= rev_d;
      istab_q <= istab_d; isbs_q <= isbs_d; tabn_q <= tabn_d;
      swcnt_q <= swcnt_d;
      if (oload) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; inarea_q <= inarea_d;
    swrow_q <= swrow_d; swlast_q <= swlast_d; swcol_q <= swcol_d; swend_q <= swend_d;
    if (oload) begin
      cell_char_o <= ochar_d;
      cursor_col_o <= ccol_d; cursor_row_o <= crow_d;
      fg_color_o <= fg_d; bg_color_o <= bg_d;
      bold_on_o <= bold_d; cursor_enabled_o <= curs_d;
      reverse_video_o <= rev_d; wrap_enabled_o <= wrap_d;
    end
  end

  assign out_valid_o = ovalid_q;

  `ASSERT_NEXT(a_read_to_result, state_q == StRead, out_valid_o, "read result lost")
  `ASSERT_ALWAYS(a_cursor_col_in_area, {2'b0, ccol_q} < ncols_q, "cursor col out of area")
  `ASSERT_ALWAYS(a_cursor_row_in_area, {2'b0, crow_q} < nrows_q, "cursor row out of area")
  `ASSERT_ALWAYS(a_no_load_when_full, !(oload && ovalid_q && out_stall_i), "result overrun")
endmodule
`default_nettype wire
